[src/stpramp_pkg.sv]
// Shared widths, command codes, register indexes and controller states for the ramp generator.
package stpramp_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned PROD_W  = POS_W + SPEED_W;

    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ZERO  = 2'd2;

    localparam logic [IDX_W-1:0] REG_MIN_SPEED  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL_RATE = 2'd2;
    localparam logic [IDX_W-1:0] REG_DECEL_RATE = 2'd3;

    localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 16'd10;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 16'd1000;
    localparam logic [SPEED_W-1:0] ACCEL_RATE_RST = 16'd1;
    localparam logic [SPEED_W-1:0] DECEL_RATE_RST = 16'd256;

    localparam int unsigned CAP_SHIFT = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MULWAIT,
        S_RAMP,
        S_CAP,
        S_DIVGO,
        S_DIVWAIT,
        S_OUT
    } state_t;

endpackage

[src/stpramp_ifs.sv]
// Handshake interfaces for the command, result and register write channels.
interface stpramp_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [stpramp_pkg::CMD_W-1:0]        command;
    logic signed [stpramp_pkg::POS_W-1:0] target;
    logic [stpramp_pkg::TIME_W-1:0]       now_ms;

    modport source (output valid, output command, output target, output now_ms, input ready);
    modport sink (input valid, input command, input target, input now_ms, output ready);
endinterface

interface stpramp_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [stpramp_pkg::POS_W-1:0] position;
    logic                                 moving;
    logic                                 direction;
    logic [stpramp_pkg::SPEED_W-1:0]      reload_value;
    logic                                 restart_timer;

    modport source (output valid, output position, output moving, output direction,
                    output reload_value, output restart_timer, input ready);
    modport sink (input valid, input position, input moving, input direction,
                  input reload_value, input restart_timer, output ready);
endinterface

interface stpramp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stpramp_pkg::IDX_W-1:0]     index;
    logic [stpramp_pkg::SPEED_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/stpramp_mul.sv]
// Bit-serial shift-add multiplier, 32 by 16 bits, one multiplier bit per cycle.
module stpramp_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [stpramp_pkg::POS_W-1:0]       multiplicand,
    input  logic [stpramp_pkg::SPEED_W-1:0]     multiplier,
    output logic                                done,
    output logic [stpramp_pkg::PROD_W-1:0]      product
);

    localparam int unsigned CNT_W = $clog2(stpramp_pkg::SPEED_W);

    logic [stpramp_pkg::PROD_W-1:0] acc_reg;
    logic [stpramp_pkg::PROD_W-1:0] acc_next;
    logic [stpramp_pkg::POS_W-1:0]  mcand_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [stpramp_pkg::POS_W:0]    upper_sum;

    always_comb
    begin
        upper_sum = {1'b0, acc_reg[stpramp_pkg::PROD_W-1:stpramp_pkg::SPEED_W]}
                  + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next  = {upper_sum, acc_reg[stpramp_pkg::SPEED_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(stpramp_pkg::SPEED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= multiplicand;
            acc_reg   <= {{stpramp_pkg::POS_W{1'b0}}, multiplier};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[src/stpramp_div.sv]
// Restoring divider that forms 65535 divided by the speed, one quotient bit per cycle.
module stpramp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [stpramp_pkg::SPEED_W-1:0]     divisor,
    output logic                                done,
    output logic [stpramp_pkg::SPEED_W-1:0]     quotient
);

    localparam int unsigned CNT_W = $clog2(stpramp_pkg::SPEED_W);

    logic [stpramp_pkg::SPEED_W-1:0] rem_reg;
    logic [stpramp_pkg::SPEED_W-1:0] rem_next;
    logic [stpramp_pkg::SPEED_W-1:0] quo_reg;
    logic [stpramp_pkg::SPEED_W-1:0] dsr_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [stpramp_pkg::SPEED_W:0]   trial;
    logic                            fits;

    // The dividend is all ones, so every step shifts a one into the remainder.
    always_comb
    begin
        trial = {rem_reg, 1'b1};
        fits  = trial >= {1'b0, dsr_reg};
        if (fits)
        begin
            rem_next = stpramp_pkg::SPEED_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[stpramp_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(stpramp_pkg::SPEED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[stpramp_pkg::SPEED_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/stepper_trapezoid_ramp_top.sv]
// Top level of the stepper trapezoidal ramp generator: registers, controller and result stage.
// One command is worked on at a time and each gives one result beat. A step-pulse beat
// that keeps the motor moving passes from acceptance to result valid through the position
// check, the two bit-serial 32 by 16 multipliers that run side by side for the ramp gain
// and the braking cap, the limiting states S_RAMP and S_CAP, the start of the bit-serial
// divider that forms the timer reload, the divider itself and the load of the output
// register. A pulse that reaches the target skips the multipliers and limiting, and every
// other command passes only through the divider and the output load. The next command beat
// can be taken in the cycle after the result is loaded. The result is held in an output
// register, so the next command beat is accepted while an earlier result still waits.
// Register writes are taken at any time and should be made only while the block is idle.
module stepper_trapezoid_ramp_top (
    input  logic                 clk,
    input  logic                 rst_n,
    stpramp_cmd_if.sink          cmd,
    stpramp_res_if.source        res,
    stpramp_cfg_if.sink          cfg
);

    localparam int unsigned CAP_HI = stpramp_pkg::SPEED_W + stpramp_pkg::CAP_SHIFT;

    stpramp_pkg::state_t state_reg;
    stpramp_pkg::state_t state_next;

    logic [stpramp_pkg::SPEED_W-1:0] min_speed_reg;
    logic [stpramp_pkg::SPEED_W-1:0] max_speed_reg;
    logic [stpramp_pkg::SPEED_W-1:0] accel_rate_reg;
    logic [stpramp_pkg::SPEED_W-1:0] decel_rate_reg;

    logic [stpramp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [stpramp_pkg::POS_W-1:0]   goal_reg, goal_next;
    logic [stpramp_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [stpramp_pkg::TIME_W-1:0]  last_reg, last_next;
    logic [stpramp_pkg::TIME_W-1:0]  now_reg, now_next;
    logic                            moving_reg, moving_next;
    logic                            dir_reg, dir_next;
    logic                            restart_reg, restart_next;
    logic [stpramp_pkg::SPEED_W-1:0] reload_reg, reload_next;

    logic                            out_valid_reg, out_valid_next;
    logic [stpramp_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;
    logic                            out_moving_reg, out_moving_next;
    logic                            out_dir_reg, out_dir_next;
    logic [stpramp_pkg::SPEED_W-1:0] out_reload_reg, out_reload_next;
    logic                            out_restart_reg, out_restart_next;

    logic                            mul_start;
    logic                            div_start;
    logic                            gain_done;
    logic                            cap_done;
    logic                            div_done;
    logic [stpramp_pkg::PROD_W-1:0]  gain_prod;
    logic [stpramp_pkg::PROD_W-1:0]  cap_prod;
    logic [stpramp_pkg::SPEED_W-1:0] div_quo;

    logic [stpramp_pkg::TIME_W-1:0]  elapsed;
    logic [stpramp_pkg::POS_W-1:0]   remaining;
    logic                            arrived;
    logic                            tgt_fwd;
    logic                            tgt_equal;
    logic [stpramp_pkg::SPEED_W:0]   ramp_sum;
    logic [stpramp_pkg::SPEED_W-1:0] cap_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg  <= stpramp_pkg::MIN_SPEED_RST;
            max_speed_reg  <= stpramp_pkg::MAX_SPEED_RST;
            accel_rate_reg <= stpramp_pkg::ACCEL_RATE_RST;
            decel_rate_reg <= stpramp_pkg::DECEL_RATE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                stpramp_pkg::REG_MIN_SPEED:  min_speed_reg  <= cfg.data;
                stpramp_pkg::REG_MAX_SPEED:  max_speed_reg  <= cfg.data;
                stpramp_pkg::REG_ACCEL_RATE: accel_rate_reg <= cfg.data;
                stpramp_pkg::REG_DECEL_RATE: decel_rate_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    stpramp_mul u_gain_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (elapsed),
        .multiplier   (accel_rate_reg),
        .done         (gain_done),
        .product      (gain_prod)
    );

    stpramp_mul u_cap_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (remaining),
        .multiplier   (decel_rate_reg),
        .done         (cap_done),
        .product      (cap_prod)
    );

    stpramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (speed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        elapsed   = now_reg - last_reg;
        remaining = dir_reg ? (goal_reg - pos_reg) : (pos_reg - goal_reg);
        arrived   = dir_reg ? ($signed(pos_reg) >= $signed(goal_reg))
                            : ($signed(pos_reg) <= $signed(goal_reg));
        tgt_fwd   = $signed(cmd.target) > $signed(pos_reg);
        tgt_equal = cmd.target == $signed(pos_reg);
        ramp_sum  = {1'b0, speed_reg} + {1'b0, gain_prod[stpramp_pkg::SPEED_W-1:0]};
        cap_low   = cap_prod[CAP_HI-1:stpramp_pkg::CAP_SHIFT];
    end

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        goal_next        = goal_reg;
        speed_next       = speed_reg;
        last_next        = last_reg;
        now_next         = now_reg;
        moving_next      = moving_reg;
        dir_next         = dir_reg;
        restart_next     = restart_reg;
        reload_next      = reload_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_pos_next     = out_pos_reg;
        out_moving_next  = out_moving_reg;
        out_dir_next     = out_dir_reg;
        out_reload_next  = out_reload_reg;
        out_restart_next = out_restart_reg;
        mul_start        = 1'b0;
        div_start        = 1'b0;
        cmd.ready        = 1'b0;

        unique case (state_reg)
            stpramp_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    restart_next = 1'b0;
                    now_next     = cmd.now_ms;
                    state_next   = stpramp_pkg::S_DIVGO;
                    priority if (cmd.command == stpramp_pkg::CMD_MOVE)
                    begin
                        goal_next = cmd.target;
                        if (tgt_equal)
                        begin
                            moving_next = 1'b0;
                        end
                        else if (!(moving_reg && (tgt_fwd == dir_reg)))
                        begin
                            moving_next  = 1'b1;
                            dir_next     = tgt_fwd;
                            speed_next   = min_speed_reg;
                            last_next    = cmd.now_ms;
                            restart_next = 1'b1;
                        end
                    end
                    else if (cmd.command == stpramp_pkg::CMD_PULSE)
                    begin
                        if (moving_reg)
                        begin
                            pos_next   = dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                            state_next = stpramp_pkg::S_CHECK;
                        end
                    end
                    else if (cmd.command == stpramp_pkg::CMD_ZERO)
                    begin
                        moving_next = 1'b0;
                        pos_next    = '0;
                    end
                end
            end

            stpramp_pkg::S_CHECK:
            begin
                if (arrived)
                begin
                    moving_next = 1'b0;
                    state_next  = stpramp_pkg::S_DIVGO;
                end
                else
                begin
                    mul_start  = 1'b1;
                    last_next  = now_reg;
                    state_next = stpramp_pkg::S_MULWAIT;
                end
            end

            stpramp_pkg::S_MULWAIT:
            begin
                if (gain_done)
                begin
                    state_next = stpramp_pkg::S_RAMP;
                end
            end

            stpramp_pkg::S_RAMP:
            begin
                if (gain_prod[stpramp_pkg::PROD_W-1:stpramp_pkg::SPEED_W] != '0)
                begin
                    speed_next = max_speed_reg;
                end
                else if (ramp_sum > {1'b0, max_speed_reg})
                begin
                    speed_next = max_speed_reg;
                end
                else
                begin
                    speed_next = ramp_sum[stpramp_pkg::SPEED_W-1:0];
                end
                state_next = stpramp_pkg::S_CAP;
            end

            stpramp_pkg::S_CAP:
            begin
                speed_next = speed_reg;
                if (cap_prod[stpramp_pkg::PROD_W-1:CAP_HI] == '0 && speed_reg > cap_low)
                begin
                    speed_next = cap_low;
                end
                if (speed_next < min_speed_reg)
                begin
                    speed_next = min_speed_reg;
                end
                state_next = stpramp_pkg::S_DIVGO;
            end

            stpramp_pkg::S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = stpramp_pkg::S_DIVWAIT;
            end

            stpramp_pkg::S_DIVWAIT:
            begin
                if (div_done)
                begin
                    reload_next = div_quo;
                    state_next  = stpramp_pkg::S_OUT;
                end
            end

            stpramp_pkg::S_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_pos_next     = pos_reg;
                    out_moving_next  = moving_reg;
                    out_dir_next     = dir_reg;
                    out_reload_next  = reload_reg;
                    out_restart_next = restart_reg;
                    state_next       = stpramp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = stpramp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stpramp_pkg::S_IDLE;
            pos_reg       <= '0;
            goal_reg      <= '0;
            speed_reg     <= '0;
            last_reg      <= '0;
            moving_reg    <= 1'b0;
            dir_reg       <= 1'b1;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            goal_reg      <= goal_next;
            speed_reg     <= speed_next;
            last_reg      <= last_next;
            moving_reg    <= moving_next;
            dir_reg       <= dir_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        reload_reg      <= reload_next;
        out_pos_reg     <= out_pos_next;
        out_moving_reg  <= out_moving_next;
        out_dir_reg     <= out_dir_next;
        out_reload_reg  <= out_reload_next;
        out_restart_reg <= out_restart_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.position      = out_pos_reg;
    assign res.moving        = out_moving_reg;
    assign res.direction     = out_dir_reg;
    assign res.reload_value  = out_reload_reg;
    assign res.restart_timer = out_restart_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command beat accepted while another is in progress");

    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        gain_done == cap_done)
        else $error("multipliers finished out of step");

    a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
        gain_done |-> state_reg == stpramp_pkg::S_MULWAIT)
        else $error("multiplier finished outside the wait state");

    a_speed_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stpramp_pkg::S_CAP |=> speed_reg >= min_speed_reg)
        else $error("ramp speed below the floor");

    a_restart_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_restart_reg) |-> out_moving_reg)
        else $error("timer restart reported without motion");

endmodule
